[src/grid_raycast_dda_column_core_macros.svh]
// Assertion helpers for the checker file gra_chk.sv.
`ifndef GRID_RAYCAST_DDA_COLUMN_CORE_MACROS_SVH
`define GRID_RAYCAST_DDA_COLUMN_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define GRA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define GRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[src/gra_pkg.sv]
`default_nettype none

package gra_pkg;

  localparam int unsigned MAP_SIDE  = 64;
  localparam int unsigned MAX_STEPS = 128;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned MAP_BITS  = $clog2(MAP_SIDE);
  localparam int unsigned MAP_DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int unsigned ADDR_BITS = 2 * MAP_BITS;
  localparam int unsigned STEP_BITS = $clog2(MAX_STEPS + 1);
  localparam int unsigned COORD_W   = MAP_BITS + 2;

  localparam int unsigned SCR_W      = 13;
  localparam int unsigned POS_W      = 22;
  localparam int unsigned DIR_W      = 19;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CELL_W     = 6;
  localparam int unsigned COL_W      = 12;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned LH_W       = 16;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned RAY_W      = 32;
  localparam int unsigned DIV_W      = 2 * FRAC_BITS + 1;
  localparam int unsigned DEN_W      = 32;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned MUL_A_W    = 20;
  localparam int unsigned MUL_B_W    = 33;
  localparam int unsigned MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT,
    REG_POS_X,
    REG_POS_Y,
    REG_DIR_X,
    REG_DIR_Y,
    REG_PLANE_X,
    REG_PLANE_Y
  } reg_e;

  typedef enum logic {
    CMD_WRITE,
    CMD_CAST
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              cell_is_wall;
    logic [COL_W-1:0]  column;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_out;
    logic              side;
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic [DIST_W-1:0] wall_distance;
    logic [LH_W-1:0]   slice_height;
    logic [ROW_W-1:0]  draw_start;
    logic [ROW_W-1:0]  draw_end;
    logic              no_hit;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CAM,
    OP_RAY_X,
    OP_RAY_Y,
    OP_DELTA_X,
    OP_DELTA_Y,
    OP_SIDE_X,
    OP_SIDE_Y,
    OP_STEP,
    OP_DIST,
    OP_MISS,
    OP_LH,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    DIV_CAM,
    DIV_DX,
    DIV_DY,
    DIV_LH
  } div_sel_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CAM,
    S_CAM_W,
    S_RAY_X,
    S_RAY_Y,
    S_DX,
    S_DX_W,
    S_DY,
    S_DY_W,
    S_SIDE_X,
    S_SIDE_Y,
    S_STEP0,
    S_WALK,
    S_DIST,
    S_LH,
    S_LH_W,
    S_DONE
  } state_e;

  typedef struct packed {
    logic     ready;
    logic     map_we;
    op_e      op;
    logic     div_start;
    div_sel_e div_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_cast;
    logic clearing;
    logic div_done;
    logic wall;
    logic last_step;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[src/gra_div.sv]
`default_nettype none

module gra_div import gra_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [DIV_W-1:0] quot_o,
  output logic             done_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quot_q, quot_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DIV_W-1:0] rem_sh;
  logic [DIV_W:0]   diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem_sh = {rem_q[DIV_W-2:0], quot_q[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!diff[DIV_W]) begin
        rem_d  = diff[DIV_W-1:0];
        quot_d = {quot_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[src/gra_map.sv]
`default_nettype none

module gra_map import gra_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [ADDR_BITS-1:0] wr_addr_i,
  input  logic                 wr_bit_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_BITS-1:0] rd_addr_i,
  output logic                 rd_bit_o,
  output logic                 clearing_o
);

  logic                 mem_q [MAP_DEPTH];
  logic                 rd_bit_q;
  logic                 clr_busy_q, clr_busy_d;
  logic [ADDR_BITS-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= 1'b0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_bit_i;
    end
    if (rd_en_i) begin
      rd_bit_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_bit_o   = rd_bit_q;
  assign clearing_o = clr_busy_q;

endmodule

`default_nettype wire

[src/gra_dp.sv]
`default_nettype none

module gra_dp import gra_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o
);

  logic        [SCR_W-1:0] scr_w_q, scr_h_q;
  logic        [POS_W-1:0] pos_x_q, pos_y_q;
  logic signed [DIR_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q   <= 13'd640;
      scr_h_q   <= 13'd480;
      pos_x_q   <= 22'd2097152;
      pos_y_q   <= 22'd2097152;
      dir_x_q   <= 19'sd65536;
      dir_y_q   <= 19'sd0;
      plane_x_q <= 19'sd0;
      plane_y_q <= 19'sd43254;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_SCREEN_WIDTH:  scr_w_q   <= cfg_data_i[SCR_W-1:0];
        REG_SCREEN_HEIGHT: scr_h_q   <= cfg_data_i[SCR_W-1:0];
        REG_POS_X:         pos_x_q   <= cfg_data_i[POS_W-1:0];
        REG_POS_Y:         pos_y_q   <= cfg_data_i[POS_W-1:0];
        REG_DIR_X:         dir_x_q   <= $signed(cfg_data_i[DIR_W-1:0]);
        REG_DIR_Y:         dir_y_q   <= $signed(cfg_data_i[DIR_W-1:0]);
        REG_PLANE_X:       plane_x_q <= $signed(cfg_data_i[DIR_W-1:0]);
        REG_PLANE_Y:       plane_y_q <= $signed(cfg_data_i[DIR_W-1:0]);
      endcase
    end
  end

  logic        [COL_W-1:0]   col_q;
  logic signed [RAY_W-1:0]   cam_q, rx_q, ry_q;
  logic        [DIST_W-1:0]  dx_q, dy_q, dist_q;
  logic        [ACC_W-1:0]   sx_q, sy_q;
  logic signed [COORD_W-1:0] mx_q, my_q;
  logic                      side_q, miss_q;
  logic        [STEP_BITS-1:0] steps_q;
  logic        [LH_W-1:0]    lh_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic [SCR_W-1:0] w_eff, h_eff;
  assign w_eff = (scr_w_q == '0) ? SCR_W'(1) : scr_w_q;
  assign h_eff = (scr_h_q == '0) ? SCR_W'(1) : scr_h_q;

  logic infx, infy;
  assign infx = (rx_q == '0);
  assign infy = (ry_q == '0);

  logic [DEN_W-1:0] abs_x, abs_y;
  assign abs_x = rx_q[RAY_W-1] ? DEN_W'(-rx_q) : DEN_W'(rx_q);
  assign abs_y = ry_q[RAY_W-1] ? DEN_W'(-ry_q) : DEN_W'(ry_q);

  logic [DIV_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;
  logic             div_done;

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_CAM: begin
        div_num = DIV_W'({col_q, 1'b0}) << FRAC_BITS;
        div_den = DEN_W'(w_eff);
      end
      DIV_DX: begin
        div_num = DIV_W'(1) << (2 * FRAC_BITS);
        div_den = abs_x;
      end
      DIV_DY: begin
        div_num = DIV_W'(1) << (2 * FRAC_BITS);
        div_den = abs_y;
      end
      DIV_LH: begin
        div_num = DIV_W'(h_eff) << FRAC_BITS;
        div_den = dist_q;
      end
    endcase
  end

  gra_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  logic [FRAC_BITS:0] frac_sel_x, frac_sel_y;
  assign frac_sel_x = rx_q[RAY_W-1] ? {1'b0, pos_x_q[FRAC_BITS-1:0]}
                                    : ONE_FX - {1'b0, pos_x_q[FRAC_BITS-1:0]};
  assign frac_sel_y = ry_q[RAY_W-1] ? {1'b0, pos_y_q[FRAC_BITS-1:0]}
                                    : ONE_FX - {1'b0, pos_y_q[FRAC_BITS-1:0]};

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p, mul_adj;
  logic signed [DIR_W-1:0]   dir_sel;

  always_comb begin
    mul_a   = MUL_A_W'(plane_x_q);
    mul_b   = MUL_B_W'(cam_q);
    dir_sel = dir_x_q;
    if (cmd_i.op == OP_RAY_Y) begin
      mul_a   = MUL_A_W'(plane_y_q);
      dir_sel = dir_y_q;
    end else if (cmd_i.op == OP_SIDE_X) begin
      mul_a = $signed(MUL_A_W'(frac_sel_x));
      mul_b = $signed({1'b0, dx_q});
    end else if (cmd_i.op == OP_SIDE_Y) begin
      mul_a = $signed(MUL_A_W'(frac_sel_y));
      mul_b = $signed({1'b0, dy_q});
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_adj = mul_p + $signed({{(MUL_P_W-FRAC_BITS){1'b0}},
                                    {FRAC_BITS{mul_p[MUL_P_W-1]}}});

  logic signed [RAY_W-1:0] ray_next, cam_next;
  logic        [ACC_W-1:0] side_next;
  logic        [DIST_W-1:0] delta_sat;

  assign ray_next  = RAY_W'(mul_adj >>> FRAC_BITS) + RAY_W'(dir_sel);
  assign cam_next  = $signed(div_quot[RAY_W-1:0]) - $signed(RAY_W'(ONE_FX));
  assign side_next = ACC_W'(mul_p[FRAC_BITS+DIST_W:FRAC_BITS]);
  assign delta_sat = div_quot[DIV_W-1] ? '1 : div_quot[DIST_W-1:0];

  logic                      step_x;
  logic        [ACC_W-1:0]   sx_nx, sy_nx;
  logic signed [COORD_W-1:0] mx_nx, my_nx;

  always_comb begin
    step_x = !infx && (infy || (sx_q < sy_q));
    sx_nx  = sx_q;
    sy_nx  = sy_q;
    mx_nx  = mx_q;
    my_nx  = my_q;
    if (step_x) begin
      sx_nx = sx_q + ACC_W'(dx_q);
      mx_nx = mx_q + (rx_q[RAY_W-1] ? -COORD_W'(1) : COORD_W'(1));
    end else begin
      sy_nx = sy_q + ACC_W'(dy_q);
      my_nx = my_q + (ry_q[RAY_W-1] ? -COORD_W'(1) : COORD_W'(1));
    end
  end

  logic rd_bit, clearing;

  gra_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cmd_i.map_we),
    .wr_addr_i  ({in_data_i.cell_y[MAP_BITS-1:0], in_data_i.cell_x[MAP_BITS-1:0]}),
    .wr_bit_i   (in_data_i.cell_is_wall),
    .rd_en_i    (cmd_i.op == OP_STEP),
    .rd_addr_i  ({my_nx[MAP_BITS-1:0], mx_nx[MAP_BITS-1:0]}),
    .rd_bit_o   (rd_bit),
    .clearing_o (clearing)
  );

  logic [ACC_W-1:0]  dist_raw;
  logic              dist_inf;
  logic [DIST_W-1:0] dist_next;
  logic [LH_W-1:0]   lh_next;

  assign dist_raw  = side_q ? (sy_q - ACC_W'(dy_q)) : (sx_q - ACC_W'(dx_q));
  assign dist_inf  = side_q ? infy : infx;
  assign dist_next = (dist_inf || (dist_raw[ACC_W-1:DIST_W] != '0)) ? '1
                                                                    : dist_raw[DIST_W-1:0];
  assign lh_next   = ((dist_q == '0) || (div_quot[DIV_W-1:LH_W] != '0)) ? '1
                                                                        : div_quot[LH_W-1:0];

  logic [ROW_W-1:0] half_h;
  logic [LH_W-2:0]  half_lh;
  logic [LH_W-1:0]  de_sum;
  logic [ROW_W-1:0] ds_val, de_val;
  out_item_t        out_next;

  always_comb begin
    half_h  = h_eff[SCR_W-1:1];
    half_lh = lh_q[LH_W-1:1];
    ds_val  = '0;
    if ((LH_W-1)'(half_h) >= half_lh) begin
      ds_val = ROW_W'((LH_W-1)'(half_h) - half_lh);
    end
    de_sum = LH_W'(half_h) + LH_W'(half_lh);
    de_val = ROW_W'(de_sum);
    if (de_sum >= LH_W'(h_eff)) begin
      de_val = ROW_W'(h_eff - 1'b1);
    end
    out_next            = '0;
    out_next.column_out = col_q;
    if (miss_q) begin
      out_next.no_hit = 1'b1;
    end else begin
      out_next.side          = side_q;
      out_next.hit_x         = CELL_W'(mx_q[MAP_BITS-1:0]);
      out_next.hit_y         = CELL_W'(my_q[MAP_BITS-1:0]);
      out_next.wall_distance = dist_q;
      out_next.slice_height  = lh_q;
      out_next.draw_start    = ds_val;
      out_next.draw_end      = de_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_LOAD:    col_q <= in_data_i.column;
      OP_CAM:     cam_q <= cam_next;
      OP_RAY_X:   rx_q  <= ray_next;
      OP_RAY_Y:   ry_q  <= ray_next;
      OP_DELTA_X: dx_q  <= infx ? '1 : delta_sat;
      OP_DELTA_Y: dy_q  <= infy ? '1 : delta_sat;
      OP_SIDE_X: begin
        sx_q <= side_next;
        mx_q <= COORD_W'(pos_x_q[POS_W-1:FRAC_BITS]);
      end
      OP_SIDE_Y: begin
        sy_q    <= side_next;
        my_q    <= COORD_W'(pos_y_q[POS_W-1:FRAC_BITS]);
        steps_q <= '0;
      end
      OP_STEP: begin
        sx_q    <= sx_nx;
        sy_q    <= sy_nx;
        mx_q    <= mx_nx;
        my_q    <= my_nx;
        side_q  <= !step_x;
        steps_q <= steps_q + 1'b1;
      end
      OP_DIST: begin
        dist_q <= dist_next;
        miss_q <= 1'b0;
      end
      OP_MISS: miss_q <= 1'b1;
      OP_LH:   lh_q   <= lh_next;
      OP_OUT:  out_q  <= out_next;
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o.in_valid  = in_valid_i;
    status_o.in_cast   = (in_data_i.command == CMD_CAST);
    status_o.clearing  = clearing;
    status_o.div_done  = div_done;
    status_o.wall      = (mx_q[COORD_W-1:MAP_BITS] != '0) ||
                         (my_q[COORD_W-1:MAP_BITS] != '0) || rd_bit;
    status_o.last_step = (steps_q == STEP_BITS'(MAX_STEPS));
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

`default_nettype wire

[src/gra_ctrl.sv]
`default_nettype none

module gra_ctrl import gra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (!status_i.clearing) state_d = S_IDLE;
      S_IDLE:   if (status_i.in_valid && status_i.in_cast) state_d = S_CAM;
      S_CAM:    state_d = S_CAM_W;
      S_CAM_W:  if (status_i.div_done) state_d = S_RAY_X;
      S_RAY_X:  state_d = S_RAY_Y;
      S_RAY_Y:  state_d = S_DX;
      S_DX:     state_d = S_DX_W;
      S_DX_W:   if (status_i.div_done) state_d = S_DY;
      S_DY:     state_d = S_DY_W;
      S_DY_W:   if (status_i.div_done) state_d = S_SIDE_X;
      S_SIDE_X: state_d = S_SIDE_Y;
      S_SIDE_Y: state_d = S_STEP0;
      S_STEP0:  state_d = S_WALK;
      S_WALK: begin
        priority if (status_i.wall) begin
          state_d = S_DIST;
        end else if (status_i.last_step) begin
          state_d = S_DONE;
        end
      end
      S_DIST:   state_d = S_LH;
      S_LH:     state_d = S_LH_W;
      S_LH_W:   if (status_i.div_done) state_d = S_DONE;
      S_DONE:   if (status_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    cmd_o.div_sel   = DIV_CAM;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.ready  = 1'b1;
        cmd_o.map_we = status_i.in_valid && !status_i.in_cast;
        if (status_i.in_valid && status_i.in_cast) cmd_o.op = OP_LOAD;
      end
      S_CAM: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_CAM;
      end
      S_CAM_W:  if (status_i.div_done) cmd_o.op = OP_CAM;
      S_RAY_X:  cmd_o.op = OP_RAY_X;
      S_RAY_Y:  cmd_o.op = OP_RAY_Y;
      S_DX: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DX;
      end
      S_DX_W:   if (status_i.div_done) cmd_o.op = OP_DELTA_X;
      S_DY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DY;
      end
      S_DY_W:   if (status_i.div_done) cmd_o.op = OP_DELTA_Y;
      S_SIDE_X: cmd_o.op = OP_SIDE_X;
      S_SIDE_Y: cmd_o.op = OP_SIDE_Y;
      S_STEP0:  cmd_o.op = OP_STEP;
      S_WALK: begin
        priority if (status_i.wall) begin
          cmd_o.op = OP_NONE;
        end else if (status_i.last_step) begin
          cmd_o.op = OP_MISS;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      S_DIST:   cmd_o.op = OP_DIST;
      S_LH: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_LH;
      end
      S_LH_W:   if (status_i.div_done) cmd_o.op = OP_LH;
      S_DONE:   if (status_i.out_free) cmd_o.op = OP_OUT;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/grid_raycast_dda_column_core.sv]
// Grid ray caster that returns one wall column per cast item, working on a 64 by 64 wall map
// in fixed point with 16 fraction bits (wall distances in Q16.16). A write item sets one map
// cell and is taken while the core is idle. A cast item runs through a controller and one
// shared restoring divider: up to four divisions (camera coordinate, two reciprocal step
// lengths, and the line height, done only on a wall hit), the ray and side-distance setup,
// and one cycle per grid cell crossed. A finished result waits in an output register while
// the next item is accepted. After reset the map is cleared one cell per cycle, and no item
// is accepted during that time; configuration writes are taken at any time.
`default_nettype none

module grid_raycast_dda_column_core import gra_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  gra_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  gra_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  assign in_stall_o = !cmd.ready;

endmodule

`default_nettype wire

[src/gra_chk.sv]
`default_nettype none
`include "grid_raycast_dda_column_core_macros.svh"

module gra_chk import gra_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  `GRA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  `GRA_ASSERT_IMPLY(a_miss_zero, out_valid_o && out_data_o.no_hit, (out_data_o.wall_distance == '0) && (out_data_o.slice_height == '0) && (out_data_o.side == 1'b0))

  `GRA_ASSERT_IMPLY(a_zero_dist_sat, out_valid_o && !out_data_o.no_hit && (out_data_o.wall_distance == '0), out_data_o.slice_height == '1)

  `GRA_ASSERT_IMPLY(a_flat_slice, out_valid_o && !out_data_o.no_hit && (out_data_o.slice_height == '0), out_data_o.draw_start == out_data_o.draw_end)

endmodule

bind grid_raycast_dda_column_core gra_chk u_gra_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[dv/tb_grid_raycast_dda_column_core.sv]
`default_nettype none

module tb_grid_raycast_dda_column_core;
  import gra_pkg::*;

  localparam longint unsigned SAT_DIST = 64'hFFFF_FFFF;
  localparam longint CYCLE_LIMIT = 6_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  grid_raycast_dda_column_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Shadow copy of the camera registers and the wall map.
  logic [SCR_W-1:0]        m_width = 13'd640;
  logic [SCR_W-1:0]        m_height = 13'd480;
  logic [POS_W-1:0]        m_pos_x = 22'd2097152;
  logic [POS_W-1:0]        m_pos_y = 22'd2097152;
  logic signed [DIR_W-1:0] m_dir_x = 19'sd65536;
  logic signed [DIR_W-1:0] m_dir_y = 19'sd0;
  logic signed [DIR_W-1:0] m_plane_x = 19'sd0;
  logic signed [DIR_W-1:0] m_plane_y = 19'sd43254;
  bit                      wall_model [MAP_SIDE*MAP_SIDE];

  in_item_t  pending_q [$];
  out_item_t column_q [$];
  int        err_cnt = 0;
  longint    cycle_cnt = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit cell_blocked(longint x, longint y);
    if (x < 0 || y < 0 || x >= MAP_SIDE || y >= MAP_SIDE) return 1'b1;
    return wall_model[y*MAP_SIDE + x];
  endfunction

  function automatic longint unsigned step_length(longint r);
    longint unsigned a, q;
    a = (r < 0) ? -r : r;
    q = (64'd1 << 32) / a;
    return (q > SAT_DIST) ? SAT_DIST : q;
  endfunction

  function automatic out_item_t cast_column(logic [COL_W-1:0] col);
    out_item_t o;
    longint w, h, cam, rx, ry, mx, my, stx, sty, ds, de;
    longint unsigned dx, dy, fx, fy, sx, sy, perp_dist, lh;
    bit infx, infy, hit, sd;
    w = (m_width == 0) ? 1 : m_width;
    h = (m_height == 0) ? 1 : m_height;
    cam = ((longint'(col) * 2) <<< 16) / w - 65536;
    rx = longint'(m_dir_x) + (longint'(m_plane_x) * cam) / 65536;
    ry = longint'(m_dir_y) + (longint'(m_plane_y) * cam) / 65536;
    infx = (rx == 0);
    infy = (ry == 0);
    dx = infx ? SAT_DIST : step_length(rx);
    dy = infy ? SAT_DIST : step_length(ry);
    mx = m_pos_x >> 16;
    my = m_pos_y >> 16;
    fx = m_pos_x & 16'hFFFF;
    fy = m_pos_y & 16'hFFFF;
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    sx = (((rx < 0) ? fx : 65536 - fx) * dx) >> 16;
    sy = (((ry < 0) ? fy : 65536 - fy) * dy) >> 16;
    sd = 1'b0;
    hit = 1'b0;
    for (int n = 0; n < MAX_STEPS && !hit; n++) begin
      if (!infx && (infy || sx < sy)) begin
        sx += dx; mx += stx; sd = 1'b0;
      end else begin
        sy += dy; my += sty; sd = 1'b1;
      end
      hit = cell_blocked(mx, my);
    end
    o = '0;
    o.column_out = col;
    if (!hit) begin
      o.no_hit = 1'b1;
      return o;
    end
    if (!sd) perp_dist = infx ? SAT_DIST : sx - dx;
    else perp_dist = infy ? SAT_DIST : sy - dy;
    if (perp_dist > SAT_DIST) perp_dist = SAT_DIST;
    lh = (perp_dist == 0) ? 65535 : (longint'(h) << 16) / perp_dist;
    if (lh > 65535) lh = 65535;
    ds = h / 2 - longint'(lh) / 2;
    if (ds < 0) ds = 0;
    de = longint'(lh) / 2 + h / 2;
    if (de >= h) de = h - 1;
    o.side = sd;
    o.hit_x = mx[5:0];
    o.hit_y = my[5:0];
    o.wall_distance = perp_dist[31:0];
    o.slice_height = lh[15:0];
    o.draw_start = ds[11:0];
    o.draw_end = de[11:0];
    return o;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  logic accepted;
  assign accepted = in_valid && !in_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (accepted) begin
        if (in_data.command == CMD_WRITE) begin
          wall_model[in_data.cell_y*MAP_SIDE + in_data.cell_x] = in_data.cell_is_wall;
        end else begin
          column_q.push_back(cast_column(in_data.column));
        end
      end
      if (!in_valid || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switching between none, light and heavy.
  int stall_mode = 0;
  int stall_span = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_span = $urandom_range(20, 3000);
        stall_mode = $urandom_range(0, 2);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t e;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_ni && out_valid && !out_stall) begin
      if (column_q.size() == 0) begin
        $error("result for column %0d with no cast pending", out_data.column_out);
        err_cnt++;
      end else begin
        e = column_q.pop_front();
        check_field("column_out", e.column_out, out_data.column_out);
        check_field("side", e.side, out_data.side);
        check_field("hit_x", e.hit_x, out_data.hit_x);
        check_field("hit_y", e.hit_y, out_data.hit_y);
        check_field("wall_distance", e.wall_distance, out_data.wall_distance);
        check_field("slice_height", e.slice_height, out_data.slice_height);
        check_field("draw_start", e.draw_start, out_data.draw_start);
        check_field("draw_end", e.draw_end, out_data.draw_end);
        check_field("no_hit", e.no_hit, out_data.no_hit);
      end
    end
  end

  task automatic write_reg(reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      REG_SCREEN_WIDTH: m_width = val[SCR_W-1:0];
      REG_SCREEN_HEIGHT: m_height = val[SCR_W-1:0];
      REG_POS_X: m_pos_x = val;
      REG_POS_Y: m_pos_y = val;
      REG_DIR_X: m_dir_x = val[DIR_W-1:0];
      REG_DIR_Y: m_dir_y = val[DIR_W-1:0];
      REG_PLANE_X: m_plane_x = val[DIR_W-1:0];
      default: m_plane_y = val[DIR_W-1:0];
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || column_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic in_item_t map_write(int x, int y, bit w);
    in_item_t it;
    it = '0;
    it.command = CMD_WRITE;
    it.cell_x = CELL_W'(x);
    it.cell_y = CELL_W'(y);
    it.cell_is_wall = w;
    it.column = COL_W'($urandom());
    return it;
  endfunction

  function automatic in_item_t ray_cast(int col);
    in_item_t it;
    it = '0;
    it.command = CMD_CAST;
    it.cell_x = CELL_W'($urandom());
    it.cell_y = CELL_W'($urandom());
    it.cell_is_wall = 1'($urandom());
    it.column = COL_W'(col);
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_screen();
    case ($urandom_range(0, 7))
      0: return CFG_DATA_W'(1);
      1: return CFG_DATA_W'(4096);
      2: return CFG_DATA_W'(0);
      3: return CFG_DATA_W'(8191);
      default: return CFG_DATA_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_vector();
    int v;
    case ($urandom_range(0, 9))
      0: v = -131072;
      1: v = 131072;
      2: v = 0;
      3: v = $urandom_range(0, 524287);
      default: v = $urandom_range(0, 262144) - 131072;
    endcase
    return CFG_DATA_W'(v[DIR_W-1:0]);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return CFG_DATA_W'(0);
      1: return CFG_DATA_W'(4194303);
      2: return CFG_DATA_W'($urandom_range(1, 62) << 16);
      default: return CFG_DATA_W'($urandom_range(0, 4194303));
    endcase
  endfunction

  initial begin
    int cast_max;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_q.push_back(ray_cast(0));
    pending_q.push_back(ray_cast(320));
    pending_q.push_back(ray_cast(639));
    pending_q.push_back(ray_cast(4095));
    pending_q.push_back(map_write(33, 32, 1'b1));
    pending_q.push_back(map_write(0, 0, 1'b1));
    pending_q.push_back(map_write(63, 63, 1'b1));
    pending_q.push_back(ray_cast(320));
    pending_q.push_back(map_write(33, 32, 1'b0));
    pending_q.push_back(map_write(63, 63, 1'b0));
    pending_q.push_back(ray_cast(320));
    wait_drained();

    write_reg(REG_DIR_X, CFG_DATA_W'(0));
    write_reg(REG_PLANE_Y, CFG_DATA_W'(0));
    write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(0));
    pending_q.push_back(ray_cast(5));
    pending_q.push_back(ray_cast(0));
    wait_drained();

    write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(640));
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(8191));
    write_reg(REG_POS_X, CFG_DATA_W'(5 << 16));
    write_reg(REG_POS_Y, CFG_DATA_W'((5 << 16) + 32768));
    write_reg(REG_DIR_X, CFG_DATA_W'(19'h70000));
    write_reg(REG_DIR_Y, CFG_DATA_W'(0));
    write_reg(REG_PLANE_X, CFG_DATA_W'(0));
    write_reg(REG_PLANE_Y, CFG_DATA_W'(43254));
    pending_q.push_back(map_write(4, 5, 1'b1));
    pending_q.push_back(ray_cast(320));
    pending_q.push_back(ray_cast(0));
    pending_q.push_back(ray_cast(639));
    pending_q.push_back(map_write(4, 5, 1'b0));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_SCREEN_WIDTH, pick_screen());
      write_reg(REG_SCREEN_HEIGHT, pick_screen());
      write_reg(REG_POS_X, pick_pos());
      write_reg(REG_POS_Y, pick_pos());
      write_reg(REG_DIR_X, pick_vector());
      write_reg(REG_DIR_Y, pick_vector());
      write_reg(REG_PLANE_X, pick_vector());
      write_reg(REG_PLANE_Y, pick_vector());
      cast_max = (m_width == 0) ? 0 : m_width - 1;
      if (cast_max > 4095) cast_max = 4095;
      for (int i = 0; i < 210; i++) begin
        if ($urandom_range(0, 9) < 4) begin
          pending_q.push_back(map_write($urandom_range(0, 63), $urandom_range(0, 63),
                                        $urandom_range(0, 2) == 0));
        end else if ($urandom_range(0, 9) == 0) begin
          pending_q.push_back(ray_cast($urandom_range(0, 4095)));
        end else begin
          pending_q.push_back(ray_cast($urandom_range(0, cast_max)));
        end
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
